@@ hdl/evad_pkg.sv @@
package evad_pkg;

    // Field widths of the request and result channels.
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned MEAN_W   = 31;
    localparam int unsigned SIL_W    = 16;

    // The square of a 16-bit magnitude is at most 2^30 and fits 31 bits.
    localparam int unsigned SQ_W     = 31;

    // The quotient is below 2^31, so the divider resolves that many bits.
    localparam int unsigned DIV_STEPS = MEAN_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE = 2'd2;

    // Register values after reset.
    localparam logic [MEAN_W-1:0] ENTER_RESET   = 31'(300 * 300);
    localparam logic [MEAN_W-1:0] EXIT_RESET    = 31'(180 * 180);
    localparam logic [SIL_W-1:0]  SILENCE_RESET = 16'd1200;

    // Request types.
    localparam logic REQ_AUDIO      = 1'b0;
    localparam logic REQ_TURN_START = 1'b1;

    localparam int unsigned MAX_SAMPLES_DEF = 2048;

endpackage

@@ hdl/energy_vad_silence_endpoint_top.sv @@
// An audio sample request is accepted in IDLE and accumulated in ACC; a frame-end sample then
// passes DIV (the shared restoring divider, one bit a cycle; skipped on overflow) and then DONE.
// Only IDLE takes requests, so a sample is done before the next one; a turn start every cycle.
// A result waits in the output register while new requests are taken.
// Reset (rst_n, asynchronous, active low) restores the register defaults and clears all
// frame and turn state; no clearing pass is needed.
module energy_vad_silence_endpoint_top #(
    parameter int unsigned MAX_SAMPLES = evad_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic signed [evad_pkg::SAMPLE_W-1:0] sample,
    input  logic                                last_in_frame,
    input  logic [evad_pkg::TIME_W-1:0]         time_ms,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [evad_pkg::MEAN_W-1:0]         mean_square,
    output logic                                speech_now,
    output logic                                speech_seen,
    output logic                                silence_event,
    output logic                                frame_too_long,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [evad_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [evad_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // The sample counter must hold MAX_SAMPLES itself; the frame sum must hold
    // MAX_SAMPLES squares of at most 2^30 each, and keeps at least one bit above
    // the quotient bits so that the remainder always has a starting part.
    localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned SUM_W = evad_pkg::SQ_W + CNT_W;

    localparam int unsigned MEAN_W = evad_pkg::MEAN_W;
    localparam int unsigned STEP_W = evad_pkg::STEP_W;

    // The sequencer: IDLE takes requests, ACC adds the registered square to the
    // frame sum, DIV runs the shared compare-and-subtract unit once per quotient
    // bit, and DONE applies the speech decision and loads the result register.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ACC  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [MEAN_W-1:0]          enter_thr_reg;
    logic [MEAN_W-1:0]          exit_thr_reg;
    logic [evad_pkg::SIL_W-1:0] silence_ms_reg;

    // Frame and turn state.
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        overflow_reg, overflow_next;
    logic                        speech_flag_reg, speech_flag_next;
    logic                        sil_reported_reg, sil_reported_next;
    logic [evad_pkg::TIME_W-1:0] last_speech_reg, last_speech_next;

    // Request held while it is worked on. The square is formed in the accepting
    // cycle, so the multiplier is followed by a register before the add.
    logic [evad_pkg::SQ_W-1:0]   sq_reg, sq_next;
    logic                        acc_en_reg, acc_en_next;
    logic                        last_reg, last_next;
    logic [evad_pkg::TIME_W-1:0] time_reg, time_next;

    // Divider: the remainder, and a step counter. The quotient is shifted into
    // the low bits of the frame sum as the dividend bits leave it.
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // Result register.
    logic              out_valid_reg, out_valid_next;
    logic [MEAN_W-1:0] mean_reg, mean_next;
    logic              speech_now_reg, speech_now_next;
    logic              speech_seen_reg, speech_seen_next;
    logic              sil_event_reg, sil_event_next;
    logic              too_long_reg, too_long_next;

    logic                        in_fire;
    logic                        out_free;
    logic [evad_pkg::SAMPLE_W-1:0] mag;
    logic [2*evad_pkg::SAMPLE_W-1:0] mag_sq;
    logic [SUM_W-1:0]            sum_add;
    logic [CNT_W:0]              rem_shift;
    logic [CNT_W:0]              rem_diff;
    logic                        q_bit;
    logic [MEAN_W-1:0]           quotient;
    logic [evad_pkg::TIME_W-1:0] elapsed;
    logic                        is_speech;
    logic                        is_silence;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    // Magnitude of a two's-complement sample; the most negative sample gives
    // 32768, which is still exact as a 16-bit unsigned value.
    assign mag = sample[evad_pkg::SAMPLE_W-1] ? evad_pkg::SAMPLE_W'(-sample)
                                              : evad_pkg::SAMPLE_W'(sample);

    // Full-width square; at most 2^30, so the low 31 bits carry all of it.
    assign mag_sq = mag * mag;

    assign sum_add = sum_reg + (acc_en_reg ? SUM_W'(sq_reg) : SUM_W'(0));

    // One restoring division step: bring down the next dividend bit and
    // subtract the sample count where it fits.
    assign rem_shift = {rem_reg, sum_reg[MEAN_W-1]};
    assign rem_diff  = rem_shift - {1'b0, count_reg};
    assign q_bit     = (rem_shift >= {1'b0, count_reg});
    assign quotient  = sum_reg[MEAN_W-1:0];

    // Speech decision at the frame end. Elapsed time wraps modulo 2^32.
    assign elapsed    = time_reg - last_speech_reg;
    assign is_speech  = (quotient >= enter_thr_reg) ||
                        (speech_flag_reg && (quotient >= exit_thr_reg));
    assign is_silence = speech_flag_reg && !sil_reported_reg &&
                        (elapsed >= evad_pkg::TIME_W'(silence_ms_reg));

    always_comb
    begin
        state_next        = state_reg;
        sum_next          = sum_reg;
        count_next        = count_reg;
        overflow_next     = overflow_reg;
        speech_flag_next  = speech_flag_reg;
        sil_reported_next = sil_reported_reg;
        last_speech_next  = last_speech_reg;
        sq_next           = sq_reg;
        acc_en_next       = acc_en_reg;
        last_next         = last_reg;
        time_next         = time_reg;
        rem_next          = rem_reg;
        step_next         = step_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        mean_next         = mean_reg;
        speech_now_next   = speech_now_reg;
        speech_seen_next  = speech_seen_reg;
        sil_event_next    = sil_event_reg;
        too_long_next     = too_long_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (req_type == evad_pkg::REQ_TURN_START)
                    begin
                        // A new turn clears the frame and the per-turn flags;
                        // no result is produced.
                        sum_next          = '0;
                        count_next        = '0;
                        overflow_next     = 1'b0;
                        speech_flag_next  = 1'b0;
                        sil_reported_next = 1'b0;
                        last_speech_next  = '0;
                    end
                    else
                    begin
                        // Samples past the limit are dropped and mark the frame.
                        if (overflow_reg || (count_reg >= CNT_W'(MAX_SAMPLES)))
                        begin
                            overflow_next = 1'b1;
                            acc_en_next   = 1'b0;
                        end
                        else
                        begin
                            acc_en_next = 1'b1;
                        end
                        sq_next    = mag_sq[evad_pkg::SQ_W-1:0];
                        last_next  = last_in_frame;
                        time_next  = time_ms;
                        state_next = ST_ACC;
                    end
                end
            end

            ST_ACC:
            begin
                sum_next = sum_add;
                if (acc_en_reg)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                // The quotient is below 2^31, so the sum's bits above the low
                // 31 are already smaller than the count and start the remainder.
                rem_next  = CNT_W'(sum_add >> MEAN_W);
                step_next = '0;
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (overflow_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next = q_bit ? CNT_W'(rem_diff) : CNT_W'(rem_shift);
                sum_next = {sum_reg[SUM_W-1:MEAN_W], sum_reg[MEAN_W-2:0], q_bit};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(evad_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Wait here until the result register is free.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    too_long_next   = overflow_reg;
                    mean_next       = '0;
                    speech_now_next = 1'b0;
                    sil_event_next  = 1'b0;
                    speech_seen_next = speech_flag_reg;
                    if (!overflow_reg && (count_reg != '0))
                    begin
                        mean_next = quotient;
                        if (is_speech)
                        begin
                            speech_now_next  = 1'b1;
                            speech_flag_next = 1'b1;
                            speech_seen_next = 1'b1;
                            last_speech_next = time_reg;
                        end
                        else if (is_silence)
                        begin
                            sil_reported_next = 1'b1;
                            sil_event_next    = 1'b1;
                        end
                    end
                    // The accumulator is always emptied for the next frame.
                    sum_next      = '0;
                    count_next    = '0;
                    overflow_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            enter_thr_reg    <= evad_pkg::ENTER_RESET;
            exit_thr_reg     <= evad_pkg::EXIT_RESET;
            silence_ms_reg   <= evad_pkg::SILENCE_RESET;
            sum_reg          <= '0;
            count_reg        <= '0;
            overflow_reg     <= 1'b0;
            speech_flag_reg  <= 1'b0;
            sil_reported_reg <= 1'b0;
            last_speech_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sum_reg          <= sum_next;
            count_reg        <= count_next;
            overflow_reg     <= overflow_next;
            speech_flag_reg  <= speech_flag_next;
            sil_reported_reg <= sil_reported_next;
            last_speech_reg  <= last_speech_next;
            out_valid_reg    <= out_valid_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    evad_pkg::CFG_ENTER:   enter_thr_reg  <= cfg_data;
                    evad_pkg::CFG_EXIT:    exit_thr_reg   <= cfg_data;
                    evad_pkg::CFG_SILENCE: silence_ms_reg <= cfg_data[evad_pkg::SIL_W-1:0];
                    default:               ;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        sq_reg          <= sq_next;
        acc_en_reg      <= acc_en_next;
        last_reg        <= last_next;
        time_reg        <= time_next;
        rem_reg         <= rem_next;
        step_reg        <= step_next;
        mean_reg        <= mean_next;
        speech_now_reg  <= speech_now_next;
        speech_seen_reg <= speech_seen_next;
        sil_event_reg   <= sil_event_next;
        too_long_reg    <= too_long_next;
    end

    assign out_valid      = out_valid_reg;
    assign mean_square    = mean_reg;
    assign speech_now     = speech_now_reg;
    assign speech_seen    = speech_seen_reg;
    assign silence_event  = sil_event_reg;
    assign frame_too_long = too_long_reg;

`ifndef SYNTH
    // The silence event can only follow speech within the same turn.
    assert property (@(posedge clk) disable iff (!rst_n)
        sil_reported_reg |-> speech_flag_reg)
        else $error("silence reported without speech in this turn");

    // The sample counter never passes the frame limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond the frame limit");

    // The divider keeps its remainder below the divisor on every step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < count_reg))
        else $error("divider remainder not below the sample count");

    // A frame end that finds the result register free always presents a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_free) |=> (out_valid && (state_reg == ST_IDLE)))
        else $error("frame end did not load the result register");

    // The divider only leaves towards the decision step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |=> ((state_reg == ST_DIV) || (state_reg == ST_DONE)))
        else $error("divider left in an unexpected direction");
`endif

endmodule
